// ===== hw/rtl/otsu_pkg.sv =====
package otsu_pkg;

  // Input tuser codes.
  localparam logic FUNC_COUNT    = 1'b0;
  localparam logic FUNC_BINARIZE = 1'b1;

  // Output tuser codes.
  localparam logic KIND_THRESH = 1'b0;
  localparam logic KIND_PIXEL  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } otsu_mul_stat_t;

endpackage

// ===== hw/rtl/otsu_threshold_binarizer.sv =====
// Counting a pixel reads its histogram bin, then writes it back; binarizing needs no histogram access.
// The last counted pixel starts a sweep over all bins; each bin that splits the pixels costs six
// products in one bit-serial unit, DW = 2 * COUNT_WIDTH + log2(NUM_BINS) multiplier bits each.
// The threshold report follows the sweep; the histogram is zeroed during the sweep.
// After reset the histogram memory is cleared bin by bin, with no input accepted.
// Reset sets the threshold to 0 and empties the output register.
module otsu_threshold_binarizer import otsu_pkg::*; #(
  parameter int NUM_BINS    = 256,
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel
  input  logic        s_axis_tlast,   // last
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // threshold, binary_pixel
  output logic        m_axis_tuser    // kind
);

  localparam int CW  = COUNT_WIDTH;
  localparam int BIW = $clog2(NUM_BINS);
  localparam int SW  = CW + BIW;
  localparam int DW  = SW + CW;
  localparam int NW  = 2 * DW;
  localparam int EW  = 2 * CW;
  localparam int LW  = NW + EW;
  localparam int PW  = NW + DW;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CWR   = 4'd2;
  localparam logic [3:0] ST_SRD   = 4'd3;
  localparam logic [3:0] ST_SACC  = 4'd4;
  localparam logic [3:0] ST_SCHK  = 4'd5;
  localparam logic [3:0] ST_MST   = 4'd6;
  localparam logic [3:0] ST_MWT   = 4'd7;
  localparam logic [3:0] ST_SNXT  = 4'd8;
  localparam logic [3:0] ST_SDONE = 4'd9;

  localparam logic [2:0] M_A    = 3'd0;
  localparam logic [2:0] M_B    = 3'd1;
  localparam logic [2:0] M_NUM  = 3'd2;
  localparam logic [2:0] M_DEN  = 3'd3;
  localparam logic [2:0] M_LHS  = 3'd4;
  localparam logic [2:0] M_RHS  = 3'd5;

  logic [3:0]     state_q, state_d;
  logic [BIW-1:0] t_q, t_d, idx_q, idx_d, in_idx;
  logic           last_q, last_d;
  logic [CW-1:0]  total_q, total_d, n0_q, n0_d, n1;
  logic [SW-1:0]  stot_q, stot_d, s0_q, s0_d;
  logic [2:0]     step_q, step_d;
  logic [DW-1:0]  a_q, a_d, d_q, d_d, bprod;
  logic [NW-1:0]  num_q, num_d, bnum_q, bnum_d;
  logic [EW-1:0]  den_q, den_d, bden_q, bden_d;
  logic [LW-1:0]  lhs_q, lhs_d;
  logic [7:0]     bt_q, bt_d, thr_q, thr_d;
  logic           mv_q, mv_d, mk_q, mk_d;
  logic [7:0]     mthr_q, mthr_d, mbin_q, mbin_d;

  logic           out_free, t_end;
  logic           we;
  logic [BIW-1:0] waddr, raddr;
  logic [CW-1:0]  wdata, rdata;
  logic           mstart;
  logic [NW-1:0]  ma;
  logic [DW-1:0]  mb;
  logic [PW-1:0]  prod;
  otsu_mul_stat_t mstat;

  otsu_ram #(.WIDTH(CW), .DEPTH(NUM_BINS)) u_hist (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  otsu_mul #(.AW(NW), .BW(DW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mstart),
    .a_i     (ma),
    .b_i     (mb),
    .prod_o  (prod),
    .stat_o  (mstat)
  );

  assign in_idx = ({1'b0, s_axis_tdata} >= 9'(NUM_BINS)) ? BIW'(NUM_BINS - 1)
                                                         : s_axis_tdata[BIW-1:0];
  assign out_free = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign t_end = (t_q == BIW'(NUM_BINS - 1));
  assign n1 = total_q - n0_q;
  assign bprod = prod[DW-1:0];
  assign raddr = (state_q == ST_IDLE) ? in_idx : t_q;
  assign mstart = (state_q == ST_MST);

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      M_A:     begin ma = NW'(stot_q); mb = DW'(n0_q); end
      M_B:     begin ma = NW'(s0_q);   mb = DW'(total_q); end
      M_NUM:   begin ma = NW'(d_q);    mb = d_q; end
      M_DEN:   begin ma = NW'(n0_q);   mb = DW'(n1); end
      M_LHS:   begin ma = num_q;       mb = DW'(bden_q); end
      M_RHS:   begin ma = bnum_q;      mb = DW'(den_q); end
      default: begin ma = '0;          mb = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    idx_d   = idx_q;
    last_d  = last_q;
    total_d = total_q;
    stot_d  = stot_q;
    n0_d    = n0_q;
    s0_d    = s0_q;
    step_d  = step_q;
    a_d     = a_q;
    d_d     = d_q;
    num_d   = num_q;
    den_d   = den_q;
    lhs_d   = lhs_q;
    bnum_d  = bnum_q;
    bden_d  = bden_q;
    bt_d    = bt_q;
    thr_d   = thr_q;
    mv_d    = mv_q && !m_axis_tready;
    mk_d    = mk_q;
    mthr_d  = mthr_q;
    mbin_d  = mbin_q;
    we      = 1'b0;
    waddr   = t_q;
    wdata   = '0;

    case (state_q)
      ST_INIT: begin
        we  = 1'b1;
        t_d = t_q + 1'b1;
        if (t_end) begin
          t_d     = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          if (s_axis_tuser == FUNC_BINARIZE) begin
            mv_d   = 1'b1;
            mk_d   = KIND_PIXEL;
            mthr_d = thr_q;
            mbin_d = (s_axis_tdata > thr_q) ? 8'hFF : 8'h00;
          end else if (total_q != {CW{1'b1}}) begin
            idx_d   = in_idx;
            last_d  = s_axis_tlast;
            state_d = ST_CWR;
          end else if (s_axis_tlast) begin
            state_d = ST_SRD;
          end
        end
        t_d    = '0;
        n0_d   = '0;
        s0_d   = '0;
        bnum_d = '0;
        bden_d = EW'(1);
        bt_d   = '0;
      end
      ST_CWR: begin
        we      = 1'b1;
        waddr   = idx_q;
        wdata   = rdata + 1'b1;
        total_d = total_q + 1'b1;
        stot_d  = stot_q + SW'(idx_q);
        state_d = last_q ? ST_SRD : ST_IDLE;
      end
      ST_SRD: state_d = ST_SACC;
      ST_SACC: begin
        // Bin t is consumed here, so it is zeroed for the next image.
        we      = 1'b1;
        n0_d    = n0_q + rdata;
        s0_d    = s0_q + SW'(t_q) * SW'(rdata);
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        step_d  = M_A;
        state_d = (n0_q == '0 || n0_q == total_q) ? ST_SNXT : ST_MST;
      end
      ST_MST: state_d = ST_MWT;
      ST_MWT: begin
        if (mstat.done) begin
          step_d  = step_q + 1'b1;
          state_d = ST_MST;
          case (step_q)
            M_A:   a_d = bprod;
            M_B:   d_d = (a_q >= bprod) ? a_q - bprod : bprod - a_q;
            M_NUM: num_d = prod[NW-1:0];
            M_DEN: den_d = prod[EW-1:0];
            M_LHS: lhs_d = prod[LW-1:0];
            M_RHS: begin
              // Cross-multiplied ratio test; strict so the first maximum wins.
              if (lhs_q > prod[LW-1:0]) begin
                bnum_d = num_q;
                bden_d = den_q;
                bt_d   = 8'(t_q);
              end
              state_d = ST_SNXT;
            end
            default: state_d = ST_SNXT;
          endcase
        end
      end
      ST_SNXT: begin
        t_d     = t_q + 1'b1;
        state_d = t_end ? ST_SDONE : ST_SRD;
      end
      ST_SDONE: begin
        t_d = '0;
        if (out_free) begin
          mv_d    = 1'b1;
          mk_d    = KIND_THRESH;
          mthr_d  = bt_q;
          mbin_d  = '0;
          thr_d   = bt_q;
          total_d = '0;
          stot_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      t_q     <= '0;
      total_q <= '0;
      stot_q  <= '0;
      thr_q   <= '0;
      mv_q    <= 1'b0;
      step_q  <= M_A;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      total_q <= total_d;
      stot_q  <= stot_d;
      thr_q   <= thr_d;
      mv_q    <= mv_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    last_q <= last_d;
    n0_q   <= n0_d;
    s0_q   <= s0_d;
    a_q    <= a_d;
    d_q    <= d_d;
    num_q  <= num_d;
    den_q  <= den_d;
    lhs_q  <= lhs_d;
    bnum_q <= bnum_d;
    bden_q <= bden_d;
    bt_q   <= bt_d;
    mk_q   <= mk_d;
    mthr_q <= mthr_d;
    mbin_q <= mbin_d;
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = mk_q;
  assign m_axis_tdata  = {mbin_q, mthr_q};

  a_mul_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mstart |-> !mstat.busy)
    else $error("multiplier started while busy");

  a_clear_after_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SDONE && out_free) |=> (total_q == '0 && stot_q == '0))
    else $error("pixel totals not cleared after report");

  a_init_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> (total_q == '0 && !mv_q))
    else $error("activity during histogram clearing");

endmodule

// ===== hw/rtl/otsu_ram.sv =====
module otsu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/otsu_mul.sv =====
module otsu_mul import otsu_pkg::*; #(
  parameter int AW = 112,
  parameter int BW = 56
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [AW-1:0]  a_i,
  input  logic [BW-1:0]  b_i,
  output logic [AW+BW-1:0] prod_o,
  output otsu_mul_stat_t stat_o
);

  localparam int CNTW = $clog2(BW + 1);

  logic [AW+BW-1:0] p_q, p_d;
  logic [AW-1:0]    a_q;
  logic [CNTW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [AW:0]      sum;

  // Shift-add: one multiplier bit per cycle, low bits of p hold the remaining multiplier.
  assign sum = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : {(AW+1){1'b0}});
  assign p_d = {sum, p_q[BW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      p_q <= {{AW{1'b0}}, b_i};
      a_q <= a_i;
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end

  assign prod_o = p_q;
  assign stat_o = '{busy: busy_q, done: done_q};

endmodule
